// ----- hdl/bte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bte_pkg;

    // Field widths on the ports
    localparam int IDX_W = 4;
    localparam int DEG_W = 4;
    localparam int U_W   = 16;
    localparam int VAL_W = 16;

endpackage

`default_nettype wire

// ----- hdl/bernstein_term_evaluator.sv -----
// Bernstein basis evaluator: B(term_index, degree, u), u and result in unsigned
// fixed point with FRAC_BITS fraction bits (1.0 = 2^FRAC_BITS).
// Input channel: i_in_valid / o_in_stall carry term_index, degree and param_u.
// An item transfers when i_in_valid is high and o_in_stall is low; o_in_stall
// stays high for the whole computation, so one item is in flight at a time.
// Output channel: o_out_valid / i_out_stall carry basis_value and index_error
// from an output register; the next item may be taken while it waits.
// Sequencing: an index beyond the degree, or degree zero, skips the computation
// and goes straight to the output. Otherwise the work is set by the one
// multiply-add unit doing one row update per cycle over a working row memory
// with a single registered read port: a clear sweep over the degree+1 row
// entries, then degree passes, each a read setup step followed by its updates.
// Degree is saturated to MAX_DEGREE and u to 1.0 before use.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid. While i_out_stall is high the result holds, and a finished
// item waits in the sequencer until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module bernstein_term_evaluator #(
    parameter int MAX_DEGREE = 15,
    parameter int FRAC_BITS  = 15
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [bte_pkg::IDX_W-1:0] i_in_term_index,
    input  wire logic [bte_pkg::DEG_W-1:0] i_in_degree,
    input  wire logic [bte_pkg::U_W-1:0]   i_in_param_u,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [bte_pkg::VAL_W-1:0]      o_out_basis_value,
    output logic                           o_out_index_error
);
    import bte_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int W     = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_PASS,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_deg;
    logic [AW-1:0]   r_pos;
    logic [AW-1:0]   r_j;
    logic [AW-1:0]   r_k;
    logic [W-1:0]    r_u;
    logic [W-1:0]    r_a;
    logic [W-1:0]    r_rdata;
    logic [VAL_W-1:0] r_res_value;
    logic            r_res_err;

    logic [W-1:0]    r_row [DEPTH];

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [W-1:0]    mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic [AW-1:0]   in_deg;
    logic [W-1:0]    in_u;

    logic signed [W:0]     blend_diff;
    logic signed [2*W+1:0] blend_prod;
    logic signed [2*W+1:0] blend_sum;
    logic [W-1:0]          blend_val;

    assign o_in_stall = (r_state != S_IDLE);

    // Saturate degree and u
    assign in_deg = (32'(i_in_degree) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(i_in_degree);
    assign in_u   = (32'(i_in_param_u) > 32'(ONE)) ? ONE : W'(i_in_param_u);

    // (1-u)*a + u*b == a*2^F + u*(b-a): one multiply per update
    assign blend_diff = $signed({1'b0, r_rdata}) - $signed({1'b0, r_a});
    assign blend_prod = $signed({1'b0, r_u}) * blend_diff;
    assign blend_sum  = blend_prod
                      + $signed((2*W+2)'(r_a) << FRAC_BITS)
                      + $signed((2*W+2)'(HALF));
    assign blend_val  = blend_sum[FRAC_BITS +: W];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = blend_val;
        mem_raddr = r_deg;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_j == r_pos) ? ONE : '0;
            end
            S_LOAD: begin
                mem_raddr = r_deg - AW'(1);
            end
            S_PASS: begin
                mem_we    = 1'b1;
                // last update of a pass fetches row[deg] for the next pass
                mem_raddr = (r_j == r_k) ? r_deg : r_j - AW'(2);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_row[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // S_OUT drives o_out_valid itself
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_deg <= in_deg;
                        r_u   <= in_u;
                        r_pos <= in_deg - AW'(i_in_term_index);
                        r_j   <= in_deg;
                        r_k   <= AW'(1);
                        if (32'(i_in_term_index) > 32'(in_deg)) begin
                            r_res_value <= '0;
                            r_res_err   <= 1'b1;
                            r_state     <= S_OUT;
                        end else if (in_deg == '0) begin
                            r_res_value <= VAL_W'(ONE);
                            r_res_err   <= 1'b0;
                            r_state     <= S_OUT;
                        end else begin
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    // descending sweep; the last cycle issues the read of row[deg]
                    if (r_j == '0) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_j <= r_j - AW'(1);
                    end
                end
                S_LOAD: begin
                    r_a     <= r_rdata;
                    r_j     <= r_deg;
                    r_state <= S_PASS;
                end
                S_PASS: begin
                    r_a <= r_rdata;
                    if (r_j == r_k) begin
                        if (r_k == r_deg) begin
                            r_res_value <= VAL_W'(blend_val);
                            r_res_err   <= 1'b0;
                            r_state     <= S_OUT;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_j <= r_j - AW'(1);
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid       <= 1'b1;
                        o_out_basis_value <= r_res_value;
                        o_out_index_error <= r_res_err;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_index_error |-> o_out_basis_value == '0)
        else $error("index error with nonzero value");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> mem_wdata <= ONE)
        else $error("row entry above one");

    a_pass_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PASS |-> (r_j >= r_k) && (r_k <= r_deg) && (r_k != '0))
        else $error("pass indices out of range");

    a_clear_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> r_j <= r_deg)
        else $error("clear sweep beyond degree");

endmodule

`default_nettype wire
